[rtl/bmvf_pkg.sv]
// Shared types and constants for the presence-bitmap missing-value finder.
`timescale 1ns / 1ps

package bmvf_pkg;

    localparam int VALUE_COUNT_DEF = 4096;
    localparam int VALUE_W         = 12;
    localparam int WORD_INDEX_W    = 9;
    localparam int BITS_PER_WORD   = 8;
    localparam int BIT_SEL_W       = 3;
    localparam int WORD_SPAN       = 1 << WORD_INDEX_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_SCAN   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_MISSING = 2'd1,
        KIND_NONE    = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

endpackage

[rtl/bitmap_missing_value_finder.sv]
// Top level of the presence-bitmap missing-value finder.
//
// Input stream (s_*): one transaction per command. s_tuser[0] selects insert (0) or
// scan (1); s_tdata carries the value to insert and the bitmap word to scan.
// Output stream (m_*): result transactions. m_tuser gives the result kind, m_tdata
// the missing value and the running maximum, m_tlast marks the final result of a
// command. An insert gives one result; a scan gives one result per absent value of
// the word below the maximum, in ascending order, or one "none" result.
// After an input transaction is accepted, the block passes through a lookup state and
// then offers the first result in an emit state. The bitmap sits in a memory with a
// registered read; each command does one read and at most one write. One command is
// in flight at a time; s_tready is low until its last result has been taken.
// Reset: the maximum clears at once, then a clearing pass writes zero to every
// bitmap word, one per cycle; s_tready stays low meanwhile. A stalled receiver
// simply holds the current result and the block.
`timescale 1ns / 1ps

module bitmap_missing_value_finder #(
    parameter int VALUE_COUNT = bmvf_pkg::VALUE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] value, [20:12] word_index, [23:21] zero
    input  logic [bmvf_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [11:0] missing_value, [23:12] max_seen
    output logic [bmvf_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import bmvf_pkg::*;

    localparam int WORD_COUNT = (VALUE_COUNT + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int MEM_DEPTH  = (WORD_COUNT < WORD_SPAN) ? WORD_COUNT : WORD_SPAN;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [VALUE_W-1:0]       max_reg, max_next;

    cmd_t                     cmd_reg;
    logic                     ok_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic [WORD_INDEX_W-1:0]  word_reg;
    logic [BITS_PER_WORD-1:0] mask_reg, mask_next;

    logic [VALUE_W-1:0]       in_value;
    logic [WORD_INDEX_W-1:0]  in_word;
    cmd_t                     in_cmd;
    logic                     in_ok;
    logic                     in_accept;
    logic                     out_accept;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [BITS_PER_WORD-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [BITS_PER_WORD-1:0] mem_rdata;

    logic [BITS_PER_WORD-1:0] scan_mask;
    logic [BIT_SEL_W-1:0]     low_idx;
    logic                     single_bit;

    kind_t                    out_kind;
    logic [VALUE_W-1:0]       out_missing;
    logic                     out_last;
    logic                     clr_done;

    assign in_value   = s_tdata[VALUE_W-1:0];
    assign in_word    = s_tdata[VALUE_W +: WORD_INDEX_W];
    assign in_cmd     = cmd_t'(s_tuser[0]);
    assign in_ok      = (in_cmd == CMD_SCAN) ? (32'(in_word) < 32'(WORD_COUNT))
                                             : (32'(in_value) < 32'(VALUE_COUNT));
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    assign clr_done   = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));

    bmvf_bitmap_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mem_raddr = (in_cmd == CMD_SCAN) ? in_word[ADDR_W-1:0]
                                            : in_value[BIT_SEL_W +: ADDR_W];

    // Write port: zero sweep during the clearing pass, else the read-modify-write
    // of an in-range insert in the cycle after its read.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == ST_LOOKUP) && (cmd_reg == CMD_INSERT) && ok_reg;
            mem_waddr = value_reg[BIT_SEL_W +: ADDR_W];
            mem_wdata = mem_rdata | (BITS_PER_WORD'(1) << value_reg[BIT_SEL_W-1:0]);
        end
    end

    // Absent values of the word that are below the maximum and inside the range.
    always_comb
    begin
        logic [VALUE_W-1:0] v;
        for (int j = 0; j < BITS_PER_WORD; j++)
        begin
            v = {word_reg, BIT_SEL_W'(j)};
            scan_mask[j] = ok_reg && !mem_rdata[j] && (v < max_reg)
                           && (32'(v) < 32'(VALUE_COUNT));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready && out_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        m_tvalid     = (state_reg == ST_EMIT);
        clr_cnt_next = clr_cnt_reg;
        max_next     = max_reg;
        mask_next    = mask_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
            end
            ST_LOOKUP:
            begin
                mask_next = scan_mask;
                if ((cmd_reg == CMD_INSERT) && ok_reg && (value_reg > max_reg))
                begin
                    max_next = value_reg;
                end
            end
            ST_EMIT:
            begin
                if (out_accept)
                begin
                    mask_next = mask_reg & (mask_reg - BITS_PER_WORD'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    // Lowest pending missing bit
    always_comb
    begin
        low_idx = '0;
        for (int j = BITS_PER_WORD - 1; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                low_idx = BIT_SEL_W'(j);
            end
        end
    end

    assign single_bit = ((mask_reg & (mask_reg - BITS_PER_WORD'(1))) == '0);

    always_comb
    begin
        out_missing = '0;
        out_last    = 1'b1;
        if (cmd_reg == CMD_SCAN)
        begin
            if (mask_reg != '0)
            begin
                out_kind    = KIND_MISSING;
                out_missing = {word_reg, low_idx};
                out_last    = single_bit;
            end
            else
            begin
                out_kind = KIND_NONE;
            end
        end
        else
        begin
            out_kind = ok_reg ? KIND_INSERT : KIND_REJECT;
        end
    end

    assign m_tdata = {max_reg, out_missing};
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            max_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            max_reg     <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (in_accept)
        begin
            cmd_reg   <= in_cmd;
            ok_reg    <= in_ok;
            value_reg <= in_value;
            word_reg  <= in_word;
        end
    end

`ifndef ASSERT_OFF
    // One command at a time: input is never open while a result is offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // A reported missing value always lies below the running maximum.
    a_missing_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_MISSING)) |-> (m_tdata[VALUE_W-1:0] <
                                                     m_tdata[2*VALUE_W-1:VALUE_W]))
        else $error("missing value not below maximum");

    // The bitmap is written only by the clearing pass or an insert update.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_LOOKUP)))
        else $error("bitmap write outside clear or update");

    // The maximum never decreases outside reset.
    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (max_reg >= $past(max_reg)))
        else $error("maximum decreased");
`endif

endmodule

[rtl/bmvf_bitmap_mem.sv]
// Single-port-write, registered-read memory holding the presence bitmap.
`timescale 1ns / 1ps

module bmvf_bitmap_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    import bmvf_pkg::*;

    logic [BITS_PER_WORD-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
